// ===== hdl/mnea_pkg.sv =====
// package for the masked normal-equation accumulator
// holds widths, mode codes, control structs and saturating add
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mnea_pkg;

    localparam int STATE_DIM  = 4;
    localparam int ACC_STRIDE = 4;
    localparam int ACC_DEPTH  = ACC_STRIDE * ACC_STRIDE;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int IDX_W      = 2;
    localparam int ENT_W      = 2 * IDX_W;
    localparam int DIMS_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS = 2'd1;

    typedef enum logic [1:0] {
        MODE_JAC      = 2'd0,
        MODE_HESS     = 2'd1,
        MODE_JAC_SUM  = 2'd2,
        MODE_HESS_SUM = 2'd3
    } t_mode;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // control that travels with a row down the pipeline
    typedef struct packed {
        logic              valid;
        logic              keep;
        logic              fin;
        t_mode             mode;
        logic [DIMS_W-1:0] dims;
    } t_ctl;

    // state of the result snapshot handed to the output sequencer
    typedef struct packed {
        logic              busy;
        logic              is_matrix;
        logic [DIMS_W-1:0] dims;
    } t_snap;

    function automatic logic is_matrix(input t_mode m);
        is_matrix = (m == MODE_HESS) || (m == MODE_HESS_SUM);
    endfunction

    function automatic logic is_sum(input t_mode m);
        is_sum = (m == MODE_JAC_SUM) || (m == MODE_HESS_SUM);
    endfunction

    function automatic logic [DIMS_W-1:0] clamp_dims(input logic [DIMS_W-1:0] v);
        if (v == '0) begin
            clamp_dims = DIMS_W'(1);
        end else if (v > DIMS_W'(STATE_DIM)) begin
            clamp_dims = DIMS_W'(STATE_DIM);
        end else begin
            clamp_dims = v;
        end
    endfunction

    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mnea_term.sv =====
// product and term stages: one product pair per accumulator entry
// registered products, then registered saturated per-entry terms
// depends on mnea_pkg
`timescale 1ns / 1ps
`default_nettype none

module mnea_term import mnea_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_stall,
    input  wire t_ctl  i_ctl,
    input  wire t_data i_weight,
    input  wire t_data i_a [STATE_DIM],
    input  wire t_data i_b [STATE_DIM],
    output t_ctl       o_ctl,
    output t_acc       o_term [ACC_DEPTH]
);

    logic  w_mat;
    t_data w_x [ACC_DEPTH];
    t_data w_y [ACC_DEPTH];
    t_data w_u [ACC_DEPTH];
    t_data w_v [ACC_DEPTH];
    logic  w_m [ACC_DEPTH];

    t_ctl  r_ctl1;
    t_ctl  r_ctl2;
    t_acc  r_p1 [ACC_DEPTH];
    t_acc  r_p2 [ACC_DEPTH];
    logic  r_m1 [ACC_DEPTH];
    t_acc  r_term [ACC_DEPTH];

    logic  w_mat1;
    logic  w_sum1;

    assign w_mat  = is_matrix(i_ctl.mode);
    assign w_mat1 = is_matrix(r_ctl1.mode);
    assign w_sum1 = is_sum(r_ctl1.mode);

    for (genvar k = 0; k < ACC_DEPTH; k++) begin : g_ent
        localparam int RI = k / ACC_STRIDE;
        localparam int CJ = k % ACC_STRIDE;
        if (RI < STATE_DIM && CJ < STATE_DIM) begin : g_used
            t_acc w_t1;
            t_acc w_t2;

            // vector modes use weight against row element, matrix modes the outer product
            assign w_x[k] = w_mat ? i_a[RI] : i_weight;
            assign w_y[k] = i_a[CJ];
            assign w_u[k] = w_mat ? i_b[RI] : i_weight;
            assign w_v[k] = i_b[CJ];
            assign w_m[k] = i_ctl.keep && (DIMS_W'(RI) < i_ctl.dims)
                         && (DIMS_W'(CJ) < i_ctl.dims) && (w_mat || RI == 0);

            always_ff @(posedge i_clk) begin
                if (!i_stall) begin
                    r_p1[k] <= t_acc'(w_x[k]) * t_acc'(w_y[k]);
                    r_p2[k] <= t_acc'(w_u[k]) * t_acc'(w_v[k]);
                    r_m1[k] <= w_m[k];
                end
            end

            assign w_t1 = w_mat1 ? -r_p1[k] : r_p1[k];
            assign w_t2 = w_mat1 ? -r_p2[k] : r_p2[k];

            always_ff @(posedge i_clk) begin
                if (!i_stall) begin
                    if (!r_m1[k]) begin
                        r_term[k] <= '0;
                    end else if (w_sum1) begin
                        r_term[k] <= sat_add(w_t1, w_t2);
                    end else begin
                        r_term[k] <= w_t1;
                    end
                end
            end
        end else begin : g_unused
            assign w_x[k]    = '0;
            assign w_y[k]    = '0;
            assign w_u[k]    = '0;
            assign w_v[k]    = '0;
            assign w_m[k]    = 1'b0;
            assign r_p1[k]   = '0;
            assign r_p2[k]   = '0;
            assign r_m1[k]   = 1'b0;
            assign r_term[k] = '0;
        end
        assign o_term[k] = r_term[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (!i_stall) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    assign o_ctl = r_ctl2;

endmodule

`default_nettype wire

// ===== hdl/mnea_acc.sv =====
// accumulator bank with saturating adds and the result snapshot
// a final row copies the updated bank into the snapshot and clears the bank
// depends on mnea_pkg
`timescale 1ns / 1ps
`default_nettype none

module mnea_acc import mnea_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_ctl i_ctl,
    input  wire t_acc i_term [ACC_DEPTH],
    input  wire logic i_snap_done,
    output logic      o_stall,
    output t_snap     o_snap,
    output t_acc      o_snap_val [ACC_DEPTH]
);

    t_acc              r_acc [ACC_DEPTH];
    t_acc              r_snap_val [ACC_DEPTH];
    logic              r_busy;
    logic              r_snap_mat;
    logic [DIMS_W-1:0] r_snap_dims;
    t_acc              n_sum [ACC_DEPTH];
    logic              w_commit;

    // a final row waits while the previous snapshot still drains
    assign o_stall  = i_ctl.valid && i_ctl.fin && r_busy;
    assign w_commit = i_ctl.valid && !o_stall;

    always_comb begin
        for (int k = 0; k < ACC_DEPTH; k++) begin
            n_sum[k] = sat_add(r_acc[k], i_term[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '{default: '0};
            r_busy <= 1'b0;
        end else begin
            if (w_commit) begin
                if (i_ctl.fin) begin
                    r_acc <= '{default: '0};
                end else begin
                    r_acc <= n_sum;
                end
            end
            if (w_commit && i_ctl.fin) begin
                r_busy <= 1'b1;
            end else if (i_snap_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && i_ctl.fin) begin
            r_snap_val  <= n_sum;
            r_snap_mat  <= is_matrix(i_ctl.mode);
            r_snap_dims <= i_ctl.dims;
        end
    end

    assign o_snap     = '{busy: r_busy, is_matrix: r_snap_mat, dims: r_snap_dims};
    assign o_snap_val = r_snap_val;

    a_snap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && i_ctl.fin) |=> (r_busy && r_acc[0] == '0 && r_acc[ACC_DEPTH-1] == '0))
        else $error("final row did not load snapshot and clear bank");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && i_ctl.fin) |-> !r_busy)
        else $error("snapshot overwritten while draining");

endmodule

`default_nettype wire

// ===== hdl/mnea_out.sv =====
// output sequencer: walks the snapshot entry by entry, row-major
// registered output stage with valid/stall transfer
// depends on mnea_pkg
`timescale 1ns / 1ps
`default_nettype none

module mnea_out import mnea_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_stall,
    input  wire t_snap i_snap,
    input  wire t_acc  i_snap_val [ACC_DEPTH],
    output logic       o_snap_done,
    output logic       o_valid,
    output logic [IDX_W-1:0] o_row_index,
    output logic [IDX_W-1:0] o_col_index,
    output t_acc       o_value,
    output logic       o_last_entry
);

    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_row;
    logic [IDX_W-1:0]  r_o_col;
    t_acc              r_o_value;
    logic              r_o_last;

    logic [DIMS_W-1:0] w_dm1;
    logic [IDX_W-1:0]  w_nm1;
    logic [IDX_W-1:0]  w_row;
    logic [ENT_W-1:0]  w_idx;
    logic              w_last_col;
    logic              w_last;
    logic              w_load;

    assign w_dm1      = i_snap.dims - DIMS_W'(1);
    assign w_nm1      = w_dm1[IDX_W-1:0];
    assign w_row      = i_snap.is_matrix ? r_i : '0;
    assign w_idx      = {w_row, r_j};
    assign w_last_col = (r_j == w_nm1);
    assign w_last     = w_last_col && (!i_snap.is_matrix || r_i == w_nm1);
    assign w_load     = i_snap.busy && (!r_o_valid || !i_stall);

    assign o_snap_done = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i       <= '0;
            r_j       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_load) begin
                if (w_last_col) begin
                    r_j <= '0;
                    r_i <= w_last ? '0 : r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_row   <= w_row;
            r_o_col   <= r_j;
            r_o_value <= i_snap_val[w_idx];
            r_o_last  <= w_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_row_index  = r_o_row;
    assign o_col_index  = r_o_col;
    assign o_value      = r_o_value;
    assign o_last_entry = r_o_last;

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_i == '0 && r_j == '0))
        else $error("entry counters did not wrap after last entry");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_stall && !w_load) |=> !r_o_valid)
        else $error("output held valid after transfer with nothing to load");

endmodule

`default_nettype wire

// ===== hdl/masked_normal_equation_accumulator.sv =====
// pipeline: a row is registered, multiplied, turned into terms and added to the accumulators;
// a final row's result is copied into the snapshot and leaves through the registered output stage
// throughput: one row per cycle; a final row waits at the accumulate stage only while
// the previous snapshot still drains (n entries in vector modes, n*n in matrix modes)
// reset: synchronous active low; mode 0, active dims 4, accumulators zero, no output
// depends on mnea_pkg, mnea_term, mnea_acc, mnea_out
`timescale 1ns / 1ps
`default_nettype none

module masked_normal_equation_accumulator import mnea_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_keep,
    input  wire t_data                 i_weight,
    input  wire t_data                 i_first_row_0,
    input  wire t_data                 i_first_row_1,
    input  wire t_data                 i_first_row_2,
    input  wire t_data                 i_first_row_3,
    input  wire t_data                 i_second_row_0,
    input  wire t_data                 i_second_row_1,
    input  wire t_data                 i_second_row_2,
    input  wire t_data                 i_second_row_3,
    input  wire logic                  i_final_row,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [IDX_W-1:0]           o_row_index,
    output logic [IDX_W-1:0]           o_col_index,
    output t_acc                       o_value,
    output logic                       o_last_entry
);

    t_mode             r_mode;
    logic [DIMS_W-1:0] r_dims;

    t_ctl  r_ctl0;
    t_data r_weight;
    t_data r_a [STATE_DIM];
    t_data r_b [STATE_DIM];
    t_data w_a_in [ACC_STRIDE];
    t_data w_b_in [ACC_STRIDE];

    t_ctl  w_ctl2;
    t_acc  w_term [ACC_DEPTH];
    t_snap w_snap;
    t_acc  w_snap_val [ACC_DEPTH];
    logic  w_snap_done;
    logic  w_stall;

    assign w_a_in = '{i_first_row_0, i_first_row_1, i_first_row_2, i_first_row_3};
    assign w_b_in = '{i_second_row_0, i_second_row_1, i_second_row_2, i_second_row_3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_JAC;
            r_dims <= DIMS_W'(STATE_DIM);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE) begin
                r_mode <= t_mode'(i_cfg_data[1:0]);
            end else if (i_cfg_idx == REG_DIMS) begin
                r_dims <= i_cfg_data;
            end
        end
    end

    // input register, control loads whenever not stalled, row data only when also valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (!w_stall) begin
            r_ctl0 <= '{valid: i_valid, keep: i_keep, fin: i_final_row,
                        mode: r_mode, dims: clamp_dims(r_dims)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && i_valid) begin
            r_weight <= i_weight;
            for (int e = 0; e < STATE_DIM; e++) begin
                r_a[e] <= w_a_in[e];
                r_b[e] <= w_b_in[e];
            end
        end
    end

    mnea_term u_term (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stall  (w_stall),
        .i_ctl    (r_ctl0),
        .i_weight (r_weight),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_ctl    (w_ctl2),
        .o_term   (w_term)
    );

    mnea_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl2),
        .i_term      (w_term),
        .i_snap_done (w_snap_done),
        .o_stall     (w_stall),
        .o_snap      (w_snap),
        .o_snap_val  (w_snap_val)
    );

    mnea_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stall      (i_stall),
        .i_snap       (w_snap),
        .i_snap_val   (w_snap_val),
        .o_snap_done  (w_snap_done),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_value      (o_value),
        .o_last_entry (o_last_entry)
    );

    assign o_stall = w_stall;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for masked_normal_equation_accumulator: drives pixel rows and register writes,
// predicts the emitted vectors and matrices and checks every entry in order
// depends on mnea_pkg and the accumulator rtl
`timescale 1ns / 1ps

module tb_top import mnea_pkg::*;;

    localparam t_data D_MAX = 32'sh7fff_ffff;
    localparam t_data D_MIN = 32'sh8000_0000;
    localparam t_data D_ONE = 32'sh0001_0000;
    // indexes past the two registers, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ROWS   = 360;

    typedef struct {
        logic  keep;
        t_data weight;
        t_data first[4];
        t_data second[4];
        logic  fin;
    } t_row;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        t_acc             value;
        logic             last;
    } t_entry;

    class normal_eq_scoreboard;
        t_acc              sums[ACC_DEPTH];
        t_mode             mode;
        logic [DIMS_W-1:0] dims;
        t_entry            due_q[$];
        int                errors;
        int                rows_seen;
        int                entries_seen;
        int                patches_done;

        function new();
            foreach (sums[k]) sums[k] = '0;
            mode = MODE_JAC;
            dims = DIMS_W'(STATE_DIM);
            errors = 0;
            rows_seen = 0;
            entries_seen = 0;
            patches_done = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MODE) begin
                mode = t_mode'(data[1:0]);
            end else if (idx == REG_DIMS) begin
                dims = data;
            end
        endfunction

        function t_acc sat_sum(t_acc x, t_acc y);
            t_acc s;
            s = x + y;
            if (x[ACC_W-1] == y[ACC_W-1] && s[ACC_W-1] != x[ACC_W-1]) begin
                return x[ACC_W-1] ? ACC_MIN : ACC_MAX;
            end
            return s;
        endfunction

        function t_acc wide_product(t_data p, t_data q);
            return t_acc'(p) * t_acc'(q);
        endfunction

        function void note_row(t_row r);
            int     n;
            int     rows;
            logic   matrix;
            t_acc   term;
            t_entry e;
            n = (dims == 0) ? 1 : ((dims > STATE_DIM) ? STATE_DIM : int'(dims));
            matrix = (mode == MODE_HESS) || (mode == MODE_HESS_SUM);
            rows_seen++;
            if (r.keep) begin
                if (!matrix) begin
                    for (int j = 0; j < n; j++) begin
                        term = wide_product(r.weight, r.first[j]);
                        if (mode == MODE_JAC_SUM) begin
                            term = sat_sum(term, wide_product(r.weight, r.second[j]));
                        end
                        sums[j] = sat_sum(sums[j], term);
                    end
                end else begin
                    for (int i = 0; i < n; i++) begin
                        for (int j = 0; j < n; j++) begin
                            term = -wide_product(r.first[i], r.first[j]);
                            if (mode == MODE_HESS_SUM) begin
                                term = sat_sum(term, -wide_product(r.second[i], r.second[j]));
                            end
                            sums[i*ACC_STRIDE+j] = sat_sum(sums[i*ACC_STRIDE+j], term);
                        end
                    end
                end
            end
            if (r.fin) begin
                // vector modes read accumulators 0..n-1, matrix modes row-major
                rows = matrix ? n : 1;
                for (int i = 0; i < rows; i++) begin
                    for (int j = 0; j < n; j++) begin
                        e.row = IDX_W'(i);
                        e.col = IDX_W'(j);
                        e.value = sums[matrix ? i*ACC_STRIDE+j : j];
                        e.last = (i == rows-1) && (j == n-1);
                        due_q.push_back(e);
                    end
                end
                foreach (sums[k]) sums[k] = '0;
                patches_done++;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                         input t_acc value, input logic last);
            t_entry e;
            entries_seen++;
            if (due_q.size() == 0) begin
                report($sformatf("entry (%0d,%0d) value %0d with nothing pending",
                                 row, col, value));
                return;
            end
            e = due_q.pop_front();
            if (row !== e.row) report($sformatf("row index %0d, want %0d", row, e.row));
            if (col !== e.col) report($sformatf("col index %0d, want %0d", col, e.col));
            if (value !== e.value) begin
                report($sformatf("entry (%0d,%0d) value %0d, want %0d",
                                 e.row, e.col, value, e.value));
            end
            if (last !== e.last) begin
                report($sformatf("entry (%0d,%0d) last %0b, want %0b",
                                 e.row, e.col, last, e.last));
            end
        endtask

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_keep;
    t_data                 i_weight;
    t_data                 i_first_row_0, i_first_row_1, i_first_row_2, i_first_row_3;
    t_data                 i_second_row_0, i_second_row_1, i_second_row_2, i_second_row_3;
    logic                  i_final_row;
    logic                  o_valid;
    logic                  i_stall;
    logic [IDX_W-1:0]      o_row_index;
    logic [IDX_W-1:0]      o_col_index;
    t_acc                  o_value;
    logic                  o_last_entry;

    normal_eq_scoreboard sb;
    logic                calm;
    int                  phases;

    masked_normal_equation_accumulator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_keep         (i_keep),
        .i_weight       (i_weight),
        .i_first_row_0  (i_first_row_0),
        .i_first_row_1  (i_first_row_1),
        .i_first_row_2  (i_first_row_2),
        .i_first_row_3  (i_first_row_3),
        .i_second_row_0 (i_second_row_0),
        .i_second_row_1 (i_second_row_1),
        .i_second_row_2 (i_second_row_2),
        .i_second_row_3 (i_second_row_3),
        .i_final_row    (i_final_row),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_value        (o_value),
        .o_last_entry   (o_last_entry)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_draw();
        if (calm) return 0;
        if ($urandom_range(0, 1)) return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic t_data rand_elem();
        logic [15:0] lo;
        case ($urandom_range(0, 7))
            0: return D_MAX;
            1: return D_MIN;
            2: return '0;
            3, 4: begin
                lo = 16'($urandom);
                return {{16{lo[15]}}, lo};
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row rand_row(logic fin);
        t_row r;
        r.keep = ($urandom_range(0, 7) != 0);
        r.weight = rand_elem();
        for (int k = 0; k < 4; k++) begin
            r.first[k] = rand_elem();
            r.second[k] = rand_elem();
        end
        r.fin = fin;
        return r;
    endfunction

    function automatic t_row uniform_row(logic keep, t_data w, t_data a, t_data b, logic fin);
        t_row r;
        r.keep = keep;
        r.weight = w;
        for (int k = 0; k < 4; k++) begin
            r.first[k] = a;
            r.second[k] = b;
        end
        r.fin = fin;
        return r;
    endfunction

    // leaves valid high after the transfer, the caller decides what follows
    task automatic send_row(input t_row r);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_keep         <= r.keep;
        i_weight       <= r.weight;
        i_first_row_0  <= r.first[0];
        i_first_row_1  <= r.first[1];
        i_first_row_2  <= r.first[2];
        i_first_row_3  <= r.first[3];
        i_second_row_0 <= r.second[0];
        i_second_row_1 <= r.second[1];
        i_second_row_2 <= r.second[2];
        i_second_row_3 <= r.second[3];
        i_final_row    <= r.fin;
        do @(posedge i_clk); while (o_stall);
        sb.note_row(r);
    endtask

    // rows without a final flag give no result, so let the pipeline settle too
    task automatic close_phase();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.apply_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode_data,
                             input logic [CFG_DATA_W-1:0] dims_data);
        write_reg(REG_MODE, mode_data);
        write_reg(REG_DIMS, dims_data);
    endtask

    task automatic random_phase(input int budget);
        logic open_end;
        t_row r;
        // sometimes leave the patch open so the next setting reads it out
        open_end = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < budget; k++) begin
            r = rand_row($urandom_range(0, 4) == 0);
            if (k == budget - 1) r.fin = !open_end;
            send_row(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_entry(o_row_index, o_col_index, o_value, o_last_entry);
        end
    end

    // result side back-pressure, one draw per transfer
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            hold = idle_draw();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d entries still pending", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int left;
        int chunk;
        sb = new();
        calm = 1'b0;
        phases = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_keep = 1'b0;
        i_weight = '0;
        i_first_row_0 = '0;
        i_first_row_1 = '0;
        i_first_row_2 = '0;
        i_first_row_3 = '0;
        i_second_row_0 = '0;
        i_second_row_1 = '0;
        i_second_row_2 = '0;
        i_second_row_3 = '0;
        i_final_row = 1'b0;
        i_stall = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: vector of weight times row, drive it into positive saturation
        send_row(uniform_row(1'b1, D_MAX, D_MAX, '0, 1'b0));
        send_row(uniform_row(1'b1, D_MIN, D_MIN, '0, 1'b0));
        send_row(uniform_row(1'b1, D_MIN, D_MIN, '0, 1'b1));
        // skipped final row still emits zeros
        send_row(uniform_row(1'b0, D_MAX, D_MAX, D_MAX, 1'b1));
        close_phase();

        // row sum: the single term that overflows, then negative saturation
        configure({1'b0, MODE_JAC_SUM}, 3'd4);
        send_row(uniform_row(1'b1, D_MIN, D_MIN, D_MIN, 1'b1));
        send_row(uniform_row(1'b1, D_MAX, D_MIN, D_MIN, 1'b0));
        send_row(uniform_row(1'b1, D_MAX, D_MIN, D_MIN, 1'b0));
        send_row(uniform_row(1'b1, D_MAX, D_MIN, D_MIN, 1'b1));
        close_phase();

        configure({1'b0, MODE_HESS}, 3'd4);
        send_row(uniform_row(1'b1, '0, D_MIN, '0, 1'b0));
        send_row(uniform_row(1'b1, '0, D_MIN, '0, 1'b0));
        send_row(uniform_row(1'b1, '0, D_MAX, '0, 1'b1));
        send_row(uniform_row(1'b1, '0, D_MIN, '0, 1'b0));
        close_phase();

        // open matrix patch read out as a vector, zero dims acts as one
        configure({1'b0, MODE_JAC}, 3'd0);
        send_row(uniform_row(1'b1, D_ONE, D_ONE, '0, 1'b1));
        close_phase();

        // upper data bit must be dropped from the mode
        configure({1'b1, MODE_HESS_SUM}, 3'd2);
        send_row(uniform_row(1'b1, D_MAX, D_MIN, D_MIN, 1'b1));
        send_row(uniform_row(1'b1, '0, D_MAX, D_MIN, 1'b0));
        send_row(uniform_row(1'b0, D_MAX, D_MAX, D_MAX, 1'b0));
        send_row(uniform_row(1'b1, D_ONE, D_MIN, D_MAX, 1'b1));
        close_phase();

        write_reg(REG_SPARE, 3'd0);
        write_reg(REG_SPARE_HI, 3'd1);
        write_reg(REG_DIMS, 3'd7);
        send_row(rand_row(1'b1));
        close_phase();
        configure({1'b0, MODE_HESS}, 3'd3);
        send_row(rand_row(1'b1));
        close_phase();
        configure({1'b0, MODE_JAC_SUM}, 3'd1);
        send_row(rand_row(1'b1));
        close_phase();

        left = RANDOM_ROWS;
        while (left > 0) begin
            chunk = $urandom_range(20, 45);
            if (chunk > left) chunk = left;
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: configure(CFG_DATA_W'($urandom_range(0, 7)), 3'd0);
                1: configure(CFG_DATA_W'($urandom_range(0, 7)), 3'd1);
                2: configure(CFG_DATA_W'($urandom_range(0, 7)), 3'd4);
                3: configure(CFG_DATA_W'($urandom_range(0, 7)), 3'd7);
                default: configure(CFG_DATA_W'($urandom_range(0, 7)),
                                   CFG_DATA_W'($urandom_range(0, 7)));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE : REG_SPARE_HI,
                          CFG_DATA_W'($urandom_range(0, 7)));
            end
            random_phase(chunk);
            close_phase();
            left -= chunk;
            phases++;
        end

        $display("%0d rows in %0d random phases plus directed cases, %0d patches read out",
                 sb.rows_seen, phases, sb.patches_done);
        $display("%0d entries checked across all modes and dims, %0d mismatches",
                 sb.entries_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mnea_pkg.sv
hdl/mnea_term.sv
hdl/mnea_acc.sv
hdl/mnea_out.sv
hdl/masked_normal_equation_accumulator.sv
tb/sv/tb_top.sv
